>>> hdl/tcw_pkg.sv
// Shared constants, types and the microprogram of the text console writer.
// No dependencies; used by the interfaces, the sequencer and the top level.
package tcw_pkg;

	// Screen limits and tab spacing
	localparam int MAX_COLS  = 80;
	localparam int MAX_LINES = 25;
	localparam int TAB_STOP  = 8;

	// Field widths
	localparam int COL_W   = 7;
	localparam int ROW_W   = 5;
	localparam int CHAR_W  = 8;
	localparam int ATTR_W  = 8;
	localparam int ACT_W   = 2;
	localparam int CNT_W   = $clog2(TAB_STOP + 1);
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	// Register map (index taken from the word address)
	localparam logic REG_COLS  = 1'b0;
	localparam logic REG_LINES = 1'b1;

	// Reset values and clamp limits
	localparam logic [COL_W-1:0]  COLS_RST  = 7'd80;
	localparam logic [ROW_W-1:0]  LINES_RST = 5'd24;
	localparam logic [COL_W-1:0]  MIN_COLS  = 7'd8;
	localparam logic [ROW_W-1:0]  MIN_LINES = 5'd1;
	localparam logic [ATTR_W-1:0] ATTR_RST  = 8'h0e;

	// Character codes
	localparam logic [CHAR_W-1:0] CH_NUL      = 8'h00;
	localparam logic [CHAR_W-1:0] CH_ESC_FG   = 8'h01;
	localparam logic [CHAR_W-1:0] CH_ESC_BG   = 8'h02;
	localparam logic [CHAR_W-1:0] CH_ATTR_RST = 8'h03;
	localparam logic [CHAR_W-1:0] CH_TAB      = 8'h09;
	localparam logic [CHAR_W-1:0] CH_NL       = 8'h0a;
	localparam logic [CHAR_W-1:0] FILL_CHAR   = 8'h20;
	localparam logic [CHAR_W-1:0] ARG_BIAS    = 8'h08;
	localparam logic [CHAR_W-1:0] ARG_MAX     = 8'h7f;
	localparam logic [ATTR_W-1:0] FILL_ATTR   = 8'h0e;

	typedef enum logic [ACT_W-1:0] {
		ACT_CELL   = 2'd0,
		ACT_SCROLL = 2'd1,
		ACT_REPORT = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		ESC_NONE = 2'd0,
		ESC_FG   = 2'd1,
		ESC_BG   = 2'd2
	} esc_t;

	// Microprogram addresses
	typedef logic [3:0] upc_t;
	localparam upc_t P_WAIT = 4'd0;
	localparam upc_t P_DEC  = 4'd1;
	localparam upc_t P_RPT  = 4'd2;
	localparam upc_t P_MOVE = 4'd3;
	localparam upc_t P_NL   = 4'd4;
	localparam upc_t P_NLS  = 4'd5;
	localparam upc_t P_NLR  = 4'd6;
	localparam upc_t P_PUT  = 4'd7;
	localparam upc_t P_SCR  = 4'd8;

	typedef enum logic [2:0] {
		CUR_HOLD,
		CUR_SAT,
		CUR_MOVE,
		CUR_NEWLINE,
		CUR_ADVANCE
	} cur_op_t;

	typedef enum logic [1:0] {
		EM_NONE,
		EM_CELL,
		EM_SCROLL,
		EM_REPORT
	} emit_t;

	typedef enum logic [1:0] {
		LS_ONE,
		LS_PUT,
		LS_SCR
	} last_sel_t;

	typedef enum logic [2:0] {
		C_NEVER,
		C_INPUT,
		C_DISPATCH,
		C_BOTTOM,
		C_SCROLL,
		C_MORE,
		C_LEFT
	} cond_t;

	// One control word of the microprogram
	typedef struct packed {
		logic      take_in;
		logic      decode;
		cur_op_t   cur_op;
		emit_t     emit;
		last_sel_t last_sel;
		cond_t     cond_a;
		upc_t      addr_a;
		cond_t     cond_b;
		upc_t      addr_b;
		upc_t      addr_next;
	} ctl_word_t;

	// Datapath status seen by the sequencer
	typedef struct packed {
		logic in_valid;
		logic go;
		logic bottom;
		logic scroll;
		logic more;
		logic left;
		upc_t dispatch;
	} seq_stat_t;

	function automatic ctl_word_t uword(input logic take_in, input logic decode,
			input cur_op_t cur_op, input emit_t emit, input last_sel_t last_sel,
			input cond_t cond_a, input upc_t addr_a, input cond_t cond_b,
			input upc_t addr_b, input upc_t addr_next);
		ctl_word_t w;
		w.take_in   = take_in;
		w.decode    = decode;
		w.cur_op    = cur_op;
		w.emit      = emit;
		w.last_sel  = last_sel;
		w.cond_a    = cond_a;
		w.addr_a    = addr_a;
		w.cond_b    = cond_b;
		w.addr_b    = addr_b;
		w.addr_next = addr_next;
		return w;
	endfunction

	// Control store: cond_a wins over cond_b, else fall to addr_next
	function automatic ctl_word_t ucode_rom(input upc_t a);
		ctl_word_t w;
		case (a)
			P_WAIT: w = uword(1'b1, 1'b0, CUR_HOLD, EM_NONE, LS_ONE,
					C_INPUT, P_DEC, C_NEVER, P_WAIT, P_WAIT);
			P_DEC:  w = uword(1'b0, 1'b1, CUR_SAT, EM_NONE, LS_ONE,
					C_DISPATCH, P_WAIT, C_NEVER, P_WAIT, P_WAIT);
			P_RPT:  w = uword(1'b0, 1'b0, CUR_HOLD, EM_REPORT, LS_ONE,
					C_NEVER, P_WAIT, C_NEVER, P_WAIT, P_WAIT);
			P_MOVE: w = uword(1'b0, 1'b0, CUR_MOVE, EM_REPORT, LS_ONE,
					C_NEVER, P_WAIT, C_NEVER, P_WAIT, P_WAIT);
			P_NL:   w = uword(1'b0, 1'b0, CUR_HOLD, EM_NONE, LS_ONE,
					C_BOTTOM, P_NLS, C_NEVER, P_WAIT, P_NLR);
			P_NLS:  w = uword(1'b0, 1'b0, CUR_NEWLINE, EM_SCROLL, LS_ONE,
					C_NEVER, P_WAIT, C_NEVER, P_WAIT, P_WAIT);
			P_NLR:  w = uword(1'b0, 1'b0, CUR_NEWLINE, EM_REPORT, LS_ONE,
					C_NEVER, P_WAIT, C_NEVER, P_WAIT, P_WAIT);
			P_PUT:  w = uword(1'b0, 1'b0, CUR_ADVANCE, EM_CELL, LS_PUT,
					C_SCROLL, P_SCR, C_MORE, P_PUT, P_WAIT);
			P_SCR:  w = uword(1'b0, 1'b0, CUR_HOLD, EM_SCROLL, LS_SCR,
					C_LEFT, P_PUT, C_NEVER, P_WAIT, P_WAIT);
			default: w = uword(1'b0, 1'b0, CUR_HOLD, EM_NONE, LS_ONE,
					C_NEVER, P_WAIT, C_NEVER, P_WAIT, P_WAIT);
		endcase
		return w;
	endfunction

endpackage

>>> hdl/tcw_if.sv
// Valid/ready channel interfaces for request and result items.
// Depends on tcw_pkg for field widths.
interface tcw_cmd_if;
	logic                        valid;
	logic                        ready;
	logic                        req_type;
	logic [tcw_pkg::CHAR_W-1:0]  char_code;
	logic [tcw_pkg::ATTR_W-1:0]  base_attr;
	logic                        string_start;
	logic [tcw_pkg::COL_W-1:0]   target_col;
	logic [tcw_pkg::ROW_W-1:0]   target_row;

	modport source (output valid, req_type, char_code, base_attr, string_start,
		target_col, target_row, input ready);
	modport sink (input valid, req_type, char_code, base_attr, string_start,
		target_col, target_row, output ready);
endinterface

interface tcw_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [tcw_pkg::ACT_W-1:0]   action;
	logic [tcw_pkg::ROW_W-1:0]   cell_row;
	logic [tcw_pkg::COL_W-1:0]   cell_col;
	logic [tcw_pkg::CHAR_W-1:0]  cell_char;
	logic [tcw_pkg::ATTR_W-1:0]  cell_attr;
	logic [tcw_pkg::COL_W-1:0]   cursor_col;
	logic [tcw_pkg::ROW_W-1:0]   cursor_row;
	logic                        last;

	modport source (output valid, action, cell_row, cell_col, cell_char, cell_attr,
		cursor_col, cursor_row, last, input ready);
	modport sink (input valid, action, cell_row, cell_col, cell_char, cell_attr,
		cursor_col, cursor_row, last, output ready);
endinterface

>>> hdl/tcw_seq.sv
// Microprogram sequencer: step counter, control store read, jump resolution.
// Depends on tcw_pkg (control word, status struct, control store).
module tcw_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tcw_pkg::seq_stat_t    stat,
	output tcw_pkg::ctl_word_t    ctl,
	output tcw_pkg::upc_t         step
);

	tcw_pkg::upc_t upc_q;
	tcw_pkg::upc_t upc_d;

	function automatic logic cond_hit(input tcw_pkg::cond_t c, input tcw_pkg::seq_stat_t s);
		logic hit;
		case (c)
			tcw_pkg::C_INPUT:    hit = s.in_valid;
			tcw_pkg::C_DISPATCH: hit = 1'b1;
			tcw_pkg::C_BOTTOM:   hit = s.bottom;
			tcw_pkg::C_SCROLL:   hit = s.scroll;
			tcw_pkg::C_MORE:     hit = s.more;
			tcw_pkg::C_LEFT:     hit = s.left;
			default:             hit = 1'b0;
		endcase
		return hit;
	endfunction

	assign ctl  = tcw_pkg::ucode_rom(upc_q);
	assign step = upc_q;

	// Next address: first jump, second jump, then fall-through
	always_comb begin
		if (cond_hit(ctl.cond_a, stat)) begin
			upc_d = (ctl.cond_a == tcw_pkg::C_DISPATCH) ? stat.dispatch : ctl.addr_a;
		end else if (cond_hit(ctl.cond_b, stat)) begin
			upc_d = ctl.addr_b;
		end else begin
			upc_d = ctl.addr_next;
		end
	end

	// Step counter holds while the current step is stalled on the output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= tcw_pkg::P_WAIT;
		end else if (stat.go) begin
			upc_q <= upc_d;
		end
	end

endmodule

>>> hdl/text_console_writer_core.sv
// Top level of the text console writer: datapath, config registers, output register.
// Depends on tcw_pkg, tcw_if (tcw_cmd_if, tcw_rsp_if) and tcw_seq.
//
//  port   dir  kind              carries
//  cmd    in   valid/ready       one character or cursor move request per item
//  rsp    out  valid/ready       cell write, scroll or cursor report per item
//  apb    in   APB write/read    columns_used at 0x0, lines_used at 0x4
//
// A printable character runs the steps wait, decode and write, plus scroll if
// it scrolls; newline runs wait, decode, a bottom test and scroll or report;
// a nul, escape or move runs wait, decode and report or move; a tab runs wait
// and decode, then one write step per space plus one scroll step per scroll.
// A step that emits holds while the output register is full and not taken.
// Reset is immediate: no clearing pass.
module text_console_writer_core (
	input  logic                          clk,
	input  logic                          arst_n,
	tcw_cmd_if.sink                       cmd,
	tcw_rsp_if.source                     rsp,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tcw_pkg::PADDR_W-1:0]   paddr,
	input  logic [tcw_pkg::PDATA_W-1:0]   pwdata,
	output logic [tcw_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);

	tcw_pkg::ctl_word_t ctl;
	tcw_pkg::seq_stat_t stat;
	tcw_pkg::upc_t      step;

	// Configuration registers
	logic [tcw_pkg::COL_W-1:0]  cols_q;
	logic [tcw_pkg::ROW_W-1:0]  lines_q;
	logic [tcw_pkg::COL_W-1:0]  cols_eff, cols_m1;
	logic [tcw_pkg::ROW_W-1:0]  lines_eff, lines_m1;

	// Held request
	logic                        req_move_q;
	logic [tcw_pkg::CHAR_W-1:0]  char_q;
	logic [tcw_pkg::ATTR_W-1:0]  base_q;
	logic                        start_q;
	logic [tcw_pkg::COL_W-1:0]   tcol_q;
	logic [tcw_pkg::ROW_W-1:0]   trow_q;

	// Console state
	logic [tcw_pkg::COL_W-1:0]   x_q, x_d, sx, tx_sat;
	logic [tcw_pkg::ROW_W-1:0]   y_q, y_d, sy, ty_sat;
	logic [tcw_pkg::ATTR_W-1:0]  attr_q;
	tcw_pkg::esc_t               esc_q;
	logic [tcw_pkg::CNT_W-1:0]   cnt_q;
	logic [tcw_pkg::CHAR_W-1:0]  put_ch_q;

	// Decode results
	logic [tcw_pkg::ATTR_W-1:0]  attr0, dec_attr;
	tcw_pkg::esc_t               esc0, dec_esc;
	logic [tcw_pkg::CHAR_W-1:0]  c_eff, dec_ch, arg;
	logic [tcw_pkg::CNT_W-1:0]   dec_cnt;
	tcw_pkg::upc_t               dispatch;

	logic [tcw_pkg::COL_W:0]     x_nx;
	logic                        wrap, bottom, scroll;
	logic                        cmd_acc, go, emit_en, cfg_wr;

	// Output register
	logic                        rsp_valid_q;
	logic [tcw_pkg::ACT_W-1:0]   act_q, act_d;
	logic [tcw_pkg::ROW_W-1:0]   crow_q, crow_d;
	logic [tcw_pkg::COL_W-1:0]   ccol_q, ccol_d;
	logic [tcw_pkg::CHAR_W-1:0]  cch_q, cch_d;
	logic [tcw_pkg::ATTR_W-1:0]  cattr_q, cattr_d;
	logic [tcw_pkg::COL_W-1:0]   kcol_q;
	logic [tcw_pkg::ROW_W-1:0]   krow_q;
	logic                        last_q, last_d;

	tcw_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctl    (ctl),
		.step   (step)
	);

	// Effective limits, clamped
	always_comb begin
		if (cols_q < tcw_pkg::MIN_COLS) begin
			cols_eff = tcw_pkg::MIN_COLS;
		end else if (cols_q > tcw_pkg::COL_W'(tcw_pkg::MAX_COLS)) begin
			cols_eff = tcw_pkg::COL_W'(tcw_pkg::MAX_COLS);
		end else begin
			cols_eff = cols_q;
		end
		if (lines_q < tcw_pkg::MIN_LINES) begin
			lines_eff = tcw_pkg::MIN_LINES;
		end else if (lines_q > tcw_pkg::ROW_W'(tcw_pkg::MAX_LINES)) begin
			lines_eff = tcw_pkg::ROW_W'(tcw_pkg::MAX_LINES);
		end else begin
			lines_eff = lines_q;
		end
	end

	assign cols_m1  = cols_eff - tcw_pkg::COL_W'(1);
	assign lines_m1 = lines_eff - tcw_pkg::ROW_W'(1);
	assign sx       = (x_q >= cols_eff) ? cols_m1 : x_q;
	assign sy       = (y_q >= lines_eff) ? lines_m1 : y_q;
	assign tx_sat   = (tcol_q >= cols_eff) ? cols_m1 : tcol_q;
	assign ty_sat   = (trow_q >= lines_eff) ? lines_m1 : trow_q;

	// Handshake and stall
	assign cmd.ready = ctl.take_in;
	assign cmd_acc   = cmd.valid && ctl.take_in;
	assign go        = !((ctl.emit != tcw_pkg::EM_NONE) && rsp_valid_q && !rsp.ready);
	assign emit_en   = go && (ctl.emit != tcw_pkg::EM_NONE);

	// Character decode: string start, escape argument, byte class
	always_comb begin
		attr0    = start_q ? base_q : attr_q;
		esc0     = start_q ? tcw_pkg::ESC_NONE : esc_q;
		dec_attr = attr0;
		dec_esc  = esc0;
		c_eff    = char_q;
		arg      = char_q - tcw_pkg::ARG_BIAS;
		if (esc0 != tcw_pkg::ESC_NONE) begin
			dec_esc = tcw_pkg::ESC_NONE;
			if (char_q inside {[tcw_pkg::ARG_BIAS:tcw_pkg::ARG_MAX]}) begin
				if (esc0 == tcw_pkg::ESC_FG) begin
					dec_attr = {attr0[7:4], arg[3:0]};
				end else begin
					dec_attr = {arg[3:0], attr0[3:0]};
				end
				c_eff = tcw_pkg::CH_NUL;
			end
		end
		dispatch = tcw_pkg::P_PUT;
		dec_ch   = c_eff;
		dec_cnt  = tcw_pkg::CNT_W'(1);
		case (c_eff)
			tcw_pkg::CH_NUL: begin
				dispatch = tcw_pkg::P_RPT;
			end
			tcw_pkg::CH_NL: begin
				dispatch = tcw_pkg::P_NL;
			end
			tcw_pkg::CH_TAB: begin
				dec_ch  = tcw_pkg::FILL_CHAR;
				dec_cnt = tcw_pkg::CNT_W'(tcw_pkg::TAB_STOP)
					- tcw_pkg::CNT_W'(sx % tcw_pkg::TAB_STOP);
			end
			tcw_pkg::CH_ESC_FG: begin
				dec_esc  = tcw_pkg::ESC_FG;
				dispatch = tcw_pkg::P_RPT;
			end
			tcw_pkg::CH_ESC_BG: begin
				dec_esc  = tcw_pkg::ESC_BG;
				dispatch = tcw_pkg::P_RPT;
			end
			tcw_pkg::CH_ATTR_RST: begin
				dec_attr = base_q;
				dispatch = tcw_pkg::P_RPT;
			end
			default: ;
		endcase
		if (req_move_q) begin
			dispatch = tcw_pkg::P_MOVE;
		end
	end

	// Cursor arithmetic
	assign x_nx   = {1'b0, x_q} + (tcw_pkg::COL_W+1)'(1);
	assign wrap   = x_nx >= {1'b0, cols_eff};
	assign bottom = y_q >= lines_m1;
	assign scroll = wrap && bottom;

	always_comb begin
		x_d = x_q;
		y_d = y_q;
		case (ctl.cur_op)
			tcw_pkg::CUR_SAT: begin
				if (!req_move_q) begin
					x_d = sx;
					y_d = sy;
				end
			end
			tcw_pkg::CUR_MOVE: begin
				x_d = tx_sat;
				y_d = ty_sat;
			end
			tcw_pkg::CUR_NEWLINE: begin
				x_d = '0;
				y_d = bottom ? lines_m1 : y_q + tcw_pkg::ROW_W'(1);
			end
			tcw_pkg::CUR_ADVANCE: begin
				if (wrap) begin
					x_d = '0;
					y_d = bottom ? lines_m1 : y_q + tcw_pkg::ROW_W'(1);
				end else begin
					x_d = x_nx[tcw_pkg::COL_W-1:0];
				end
			end
			default: ;
		endcase
	end

	// Status to the sequencer
	assign stat.in_valid = cmd.valid;
	assign stat.go       = go;
	assign stat.bottom   = bottom;
	assign stat.scroll   = scroll;
	assign stat.more     = cnt_q > tcw_pkg::CNT_W'(1);
	assign stat.left     = cnt_q != '0;
	assign stat.dispatch = dispatch;

	// Console state and config registers
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q     <= '0;
			y_q     <= '0;
			attr_q  <= tcw_pkg::ATTR_RST;
			esc_q   <= tcw_pkg::ESC_NONE;
			cnt_q   <= tcw_pkg::CNT_W'(1);
			cols_q  <= tcw_pkg::COLS_RST;
			lines_q <= tcw_pkg::LINES_RST;
		end else begin
			if (go) begin
				x_q <= x_d;
				y_q <= y_d;
				if (ctl.decode && !req_move_q) begin
					attr_q <= dec_attr;
					esc_q  <= dec_esc;
					cnt_q  <= dec_cnt;
				end
				if (ctl.cur_op == tcw_pkg::CUR_ADVANCE) begin
					cnt_q <= cnt_q - tcw_pkg::CNT_W'(1);
				end
			end
			if (cfg_wr) begin
				case (paddr[2])
					tcw_pkg::REG_COLS:  cols_q  <= pwdata[tcw_pkg::COL_W-1:0];
					tcw_pkg::REG_LINES: lines_q <= pwdata[tcw_pkg::ROW_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// Register read
	always_comb begin
		case (paddr[2])
			tcw_pkg::REG_COLS:  prdata = tcw_pkg::PDATA_W'(cols_q);
			tcw_pkg::REG_LINES: prdata = tcw_pkg::PDATA_W'(lines_q);
			default:            prdata = '0;
		endcase
	end
	assign pready = 1'b1;

	// Request hold and character to write
	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			req_move_q <= cmd.req_type;
			char_q     <= cmd.char_code;
			base_q     <= cmd.base_attr;
			start_q    <= cmd.string_start;
			tcol_q     <= cmd.target_col;
			trow_q     <= cmd.target_row;
		end
		if (go && ctl.decode) begin
			put_ch_q <= dec_ch;
		end
	end

	// Result payload
	always_comb begin
		act_d   = tcw_pkg::ACT_REPORT;
		crow_d  = '0;
		ccol_d  = '0;
		cch_d   = '0;
		cattr_d = '0;
		case (ctl.emit)
			tcw_pkg::EM_CELL: begin
				act_d   = tcw_pkg::ACT_CELL;
				crow_d  = y_q;
				ccol_d  = x_q;
				cch_d   = put_ch_q;
				cattr_d = attr_q;
			end
			tcw_pkg::EM_SCROLL: begin
				act_d   = tcw_pkg::ACT_SCROLL;
				crow_d  = lines_m1;
				cch_d   = tcw_pkg::FILL_CHAR;
				cattr_d = tcw_pkg::FILL_ATTR;
			end
			default: ;
		endcase
		case (ctl.last_sel)
			tcw_pkg::LS_PUT: last_d = !scroll && (cnt_q == tcw_pkg::CNT_W'(1));
			tcw_pkg::LS_SCR: last_d = (cnt_q == '0);
			default:         last_d = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (emit_en) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_en) begin
			act_q   <= act_d;
			crow_q  <= crow_d;
			ccol_q  <= ccol_d;
			cch_q   <= cch_d;
			cattr_q <= cattr_d;
			kcol_q  <= x_d;
			krow_q  <= y_d;
			last_q  <= last_d;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.action     = act_q;
	assign rsp.cell_row   = crow_q;
	assign rsp.cell_col   = ccol_q;
	assign rsp.cell_char  = cch_q;
	assign rsp.cell_attr  = cattr_q;
	assign rsp.cursor_col = kcol_q;
	assign rsp.cursor_row = krow_q;
	assign rsp.last       = last_q;

	// Checks
	a_accept_decodes: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready) |=> (step == tcw_pkg::P_DEC))
		else $error("accepted item not followed by decode step");

	a_put_count: assert property (@(posedge clk) disable iff (!arst_n)
		(step == tcw_pkg::P_PUT) |-> (cnt_q != '0))
		else $error("cell write step with no cells left");

	a_cursor_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(x_q < tcw_pkg::COL_W'(tcw_pkg::MAX_COLS)) && (y_q < tcw_pkg::ROW_W'(tcw_pkg::MAX_LINES)))
		else $error("cursor outside the screen");

endmodule
